// File: src/ctl_pkg.sv
// ----------------------------------------------------------------------------
// ctl_pkg: shared types and constants for the charger thermal ladder
// Mode codes, configuration and result records, and temperature thresholds.
// ----------------------------------------------------------------------------
package ctl_pkg;

  // Charge mode coding; code 7 means "no mode yet" and behaves as oem.
  typedef enum logic [2:0] {
    MODE_OEM      = 3'd0,
    MODE_FAST     = 3'd1,
    MODE_BALANCED = 3'd2,
    MODE_SAFE     = 3'd3,
    MODE_BYPASS   = 3'd4,
    MODE_VIOLENT  = 3'd5,
    MODE_CUSTOM   = 3'd6,
    MODE_NONE     = 3'd7
  } mode_e;

  // Register indexes on the configuration port.
  localparam int unsigned ADDR_W = 5;
  localparam logic [2:0] REG_USER_MODE       = 3'd0;
  localparam logic [2:0] REG_CUSTOM_LIMIT    = 3'd1;
  localparam logic [2:0] REG_PROTECT_EIGHTY  = 3'd2;
  localparam logic [2:0] REG_SMART_CHARGING  = 3'd3;
  localparam logic [2:0] REG_NIGHT_CHARGING  = 3'd4;
  localparam logic [2:0] REG_CHARGER_PRESENT = 3'd5;

  // Temperature thresholds in whole degrees.
  localparam int TEMP_EMERG = 50;
  localparam int TEMP_HOT   = 45;
  localparam int TEMP_COOL  = 41;
  localparam int SCALE_MILLI = 1000;
  localparam int SCALE_DECI  = 10;
  localparam int RAW_MILLI_MIN = 1000;
  localparam int RAW_DECI_MIN  = 100;

  // Capacity thresholds in percent.
  localparam logic signed [7:0] CAP_DEFAULT = 8'sd50;
  localparam logic signed [7:0] CAP_EIGHTY  = 8'sd80;
  localparam logic signed [7:0] CAP_LOW     = 8'sd10;
  localparam logic signed [7:0] CAP_RECOVER = 8'sd12;

  // Dwell times in seconds.
  localparam logic [31:0] DWELL_DOWN = 32'd10;
  localparam logic [31:0] DWELL_UP   = 32'd15;

  // Limit levels.
  localparam logic [4:0] LIM_BALANCED = 5'd10;
  localparam logic [4:0] LIM_SAFE     = 5'd14;
  localparam logic [4:0] LIM_CUTOFF   = 5'd16;

  typedef struct packed {
    mode_e      sel_mode;
    logic [3:0] custom_limit;
    logic       protect_eighty;
    logic       smart_charging;
    logic       night_guard;
    logic       charger_present;
  } cfg_t;

  // Temperature band after normalization.
  typedef struct packed {
    logic emerg;
    logic hot;
    logic cool;
  } band_t;

  typedef struct packed {
    mode_e      applied_mode;
    logic [4:0] chg_limit;
    logic       chg_suspend;
    logic       smart_out;
    logic       night_out;
    logic       renegotiate_pulse;
    logic       derate_hold;
    logic       hands_off;
  } res_t;

endpackage

// File: src/ctl_band.sv
// ----------------------------------------------------------------------------
// ctl_band: temperature band classifier
// Normalizes a raw reading (thousandths, tenths or degrees) and reports
// whether it is in the emergency, hot or cool band. The scaled thresholds
// replace the division of the reading.
// ----------------------------------------------------------------------------
module ctl_band (
  input  logic signed [16:0] raw_temperature_i,
  output ctl_pkg::band_t     band_o
);

  localparam logic signed [16:0] MilliMin = 17'(ctl_pkg::RAW_MILLI_MIN);
  localparam logic signed [16:0] DeciMin  = 17'(ctl_pkg::RAW_DECI_MIN);
  localparam logic signed [16:0] MilliEmerg =
    17'(ctl_pkg::TEMP_EMERG * ctl_pkg::SCALE_MILLI);
  localparam logic signed [16:0] MilliHot =
    17'(ctl_pkg::TEMP_HOT * ctl_pkg::SCALE_MILLI);
  localparam logic signed [16:0] MilliWarm =
    17'((ctl_pkg::TEMP_COOL + 1) * ctl_pkg::SCALE_MILLI);
  localparam logic signed [16:0] DeciEmerg =
    17'(ctl_pkg::TEMP_EMERG * ctl_pkg::SCALE_DECI);
  localparam logic signed [16:0] DeciHot =
    17'(ctl_pkg::TEMP_HOT * ctl_pkg::SCALE_DECI);
  localparam logic signed [16:0] DeciWarm =
    17'((ctl_pkg::TEMP_COOL + 1) * ctl_pkg::SCALE_DECI);
  localparam logic signed [16:0] DegEmerg = 17'(ctl_pkg::TEMP_EMERG);
  localparam logic signed [16:0] DegHot   = 17'(ctl_pkg::TEMP_HOT);
  localparam logic signed [16:0] DegCool  = 17'(ctl_pkg::TEMP_COOL);

  // A truncated quotient is at least N exactly when the reading is at
  // least N times the scale, so each band is one signed compare.
  always_comb begin
    if (raw_temperature_i > MilliMin) begin
      band_o.emerg = (raw_temperature_i >= MilliEmerg);
      band_o.hot   = (raw_temperature_i >= MilliHot);
      band_o.cool  = (raw_temperature_i < MilliWarm);
    end else if (raw_temperature_i > DeciMin) begin
      band_o.emerg = (raw_temperature_i >= DeciEmerg);
      band_o.hot   = (raw_temperature_i >= DeciHot);
      band_o.cool  = (raw_temperature_i < DeciWarm);
    end else begin
      band_o.emerg = (raw_temperature_i >= DegEmerg);
      band_o.hot   = (raw_temperature_i >= DegHot);
      band_o.cool  = (raw_temperature_i <= DegCool);
    end
  end

endmodule

// File: src/ctl_core.sv
// ----------------------------------------------------------------------------
// ctl_core: mode decision and derating state
// Holds the ladder step, step time, override flag and previous mode, picks
// the effective mode for one tick and maps it onto the charger outputs.
// ----------------------------------------------------------------------------
module ctl_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  ctl_pkg::cfg_t       cfg_i,
  input  ctl_pkg::band_t      band_i,
  input  logic signed [7:0]   capacity_i,
  input  logic [31:0]         now_i,
  output ctl_pkg::res_t       res_o
);

  logic [1:0]     step_q, step_d;
  logic [31:0]    time_q, time_d;
  logic           ovr_q, ovr_d;
  ctl_pkg::mode_e prev_q, prev_d;

  ctl_pkg::mode_e    mode;
  ctl_pkg::mode_e    eff;
  logic              ov;
  logic              changed;
  logic signed [7:0] cap;
  logic [31:0]       t_base;
  logic [31:0]       el_down;
  logic [31:0]       el_up;
  logic [1:0]        step_cap;

  // Mode applied at a given derating step.
  function automatic ctl_pkg::mode_e step_mode(ctl_pkg::mode_e m, logic [1:0] step,
                                               logic [3:0] lim);
    ctl_pkg::mode_e r;
    if (step == 2'd0) begin
      r = m;
    end else if (m == ctl_pkg::MODE_SAFE) begin
      r = (step >= 2'd2) ? ctl_pkg::MODE_BYPASS : ctl_pkg::MODE_SAFE;
    end else if (m == ctl_pkg::MODE_CUSTOM) begin
      if (step == 2'd3) begin
        r = ctl_pkg::MODE_BYPASS;
      end else if (step == 2'd2) begin
        r = ctl_pkg::MODE_SAFE;
      end else begin
        r = (lim < 4'(ctl_pkg::LIM_BALANCED)) ? ctl_pkg::MODE_BALANCED
                                              : ctl_pkg::MODE_SAFE;
      end
    end else if (step == 2'd1) begin
      r = ctl_pkg::MODE_BALANCED;
    end else if (step == 2'd2) begin
      r = ctl_pkg::MODE_SAFE;
    end else begin
      r = ctl_pkg::MODE_BYPASS;
    end
    return r;
  endfunction

  assign mode     = cfg_i.sel_mode;
  assign cap      = (capacity_i <= 8'sd0) ? ctl_pkg::CAP_DEFAULT : capacity_i;
  assign t_base   = (time_q == 32'd0) ? now_i : time_q;
  assign el_down  = now_i - time_q;
  assign el_up    = now_i - t_base;
  assign step_cap = (mode == ctl_pkg::MODE_SAFE) ? 2'd1 : 2'd2;

  // Mode decision, state update and output mapping for one tick.
  always_comb begin
    step_d  = step_q;
    time_d  = time_q;
    ovr_d   = ovr_q;
    prev_d  = prev_q;
    eff     = mode;
    ov      = ovr_q;
    changed = 1'b0;
    res_o   = '0;
    if (!cfg_i.charger_present) begin
      res_o.derate_hold = ovr_q;
      res_o.hands_off   = 1'b1;
    end else if (mode == ctl_pkg::MODE_OEM || mode == ctl_pkg::MODE_NONE) begin
      ovr_d           = 1'b0;
      res_o.hands_off = 1'b1;
    end else begin
      // The 80 percent stop comes first; an override branch replaces it.
      if (cfg_i.protect_eighty && mode != ctl_pkg::MODE_BYPASS &&
          cap >= ctl_pkg::CAP_EIGHTY) begin
        eff = ctl_pkg::MODE_BYPASS;
      end

      if (mode == ctl_pkg::MODE_BYPASS) begin
        // Low-battery hysteresis.
        if (cap < ctl_pkg::CAP_LOW) begin
          eff = ctl_pkg::MODE_SAFE;
          ov  = 1'b1;
        end else if (ov && cap >= ctl_pkg::CAP_RECOVER) begin
          ov = 1'b0;
        end else if (ov) begin
          eff = ctl_pkg::MODE_SAFE;
        end
      end else if (band_i.emerg) begin
        step_d = 2'd3;
        time_d = now_i;
        eff    = ctl_pkg::MODE_BYPASS;
        ov     = 1'b1;
      end else if (band_i.hot) begin
        // Step down at once from full rate, then after each dwell up to the step cap.
        if (step_q == 2'd0) begin
          step_d = 2'd1;
          time_d = now_i;
        end else if (el_down >= ctl_pkg::DWELL_DOWN && step_q < step_cap) begin
          step_d = step_q + 2'd1;
          time_d = now_i;
        end
        eff = step_mode(mode, step_d, cfg_i.custom_limit);
        ov  = (step_d != 2'd0);
      end else if (ov && band_i.cool) begin
        // Step back up after the recovery dwell.
        time_d = t_base;
        if (el_up >= ctl_pkg::DWELL_UP) begin
          step_d = (step_q != 2'd0) ? step_q - 2'd1 : 2'd0;
          time_d = now_i;
          if (step_d == 2'd0) begin
            ov  = 1'b0;
            eff = mode;
          end else begin
            eff = step_mode(mode, step_d, cfg_i.custom_limit);
          end
        end else begin
          eff = step_mode(mode, step_q, cfg_i.custom_limit);
        end
      end else if (ov) begin
        eff = step_mode(mode, step_q, cfg_i.custom_limit);
      end
      ovr_d = ov;

      // Charger settings for the chosen mode.
      changed = (prev_q != eff);
      unique case (eff)
        ctl_pkg::MODE_VIOLENT: begin
          res_o.renegotiate_pulse = changed;
        end
        ctl_pkg::MODE_BALANCED: begin
          res_o.chg_limit = ctl_pkg::LIM_BALANCED;
          res_o.smart_out = cfg_i.smart_charging;
          res_o.night_out = cfg_i.night_guard;
        end
        ctl_pkg::MODE_SAFE: begin
          res_o.chg_limit = ctl_pkg::LIM_SAFE;
          res_o.smart_out = cfg_i.smart_charging;
          res_o.night_out = cfg_i.night_guard;
        end
        ctl_pkg::MODE_BYPASS: begin
          res_o.chg_limit   = ctl_pkg::LIM_CUTOFF;
          res_o.chg_suspend = 1'b1;
        end
        ctl_pkg::MODE_CUSTOM: begin
          res_o.chg_limit         = {1'b0, cfg_i.custom_limit};
          res_o.smart_out         = cfg_i.smart_charging;
          res_o.night_out         = cfg_i.night_guard;
          res_o.renegotiate_pulse = changed;
        end
        default: begin
          res_o.smart_out         = cfg_i.smart_charging;
          res_o.night_out         = cfg_i.night_guard;
          res_o.renegotiate_pulse = changed;
        end
      endcase
      prev_d             = eff;
      res_o.applied_mode = eff;
      res_o.derate_hold  = ov;
    end
  end

  // State advances only when a transaction leaves the input stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 2'd0;
      time_q <= 32'd0;
      ovr_q  <= 1'b0;
      prev_q <= ctl_pkg::MODE_NONE;
    end else if (fire_i) begin
      step_q <= step_d;
      time_q <= time_d;
      ovr_q  <= ovr_d;
      prev_q <= prev_d;
    end
  end

endmodule

// File: src/charger_thermal_ladder.sv
// Order: an accepted transaction is written to the input register and is loaded
// into the result register when the input stage advances, which a stalled result delays.
// Throughput: one transaction per cycle while no result stalls; the input register
// feeds the decision logic, whose state and result register load in the same cycle.
// A stalled result holds the output register; an empty input register still fills.
// Reset (rst_ni low, asynchronous) empties both stages, clears the ladder state
// and loads the configuration registers with their reset values.
// ----------------------------------------------------------------------------
// charger_thermal_ladder: charge mode enforcer with thermal derating
// Input register, temperature band and mode decision, result register, and
// an APB-style configuration register file.
// ----------------------------------------------------------------------------
module charger_thermal_ladder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Tick channel.
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [16:0]          raw_temperature_i,
  input  logic signed [7:0]           capacity_reading_i,
  input  logic [31:0]                 now_seconds_i,
  // Result channel.
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  applied_mode_o,
  output logic [4:0]                  chg_limit_o,
  output logic                        chg_suspend_o,
  output logic                        smart_out_o,
  output logic                        night_out_o,
  output logic                        renegotiate_pulse_o,
  output logic                        derate_hold_o,
  output logic                        hands_off_o,
  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ctl_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  ctl_pkg::cfg_t     cfg_q;
  logic              wr_en;
  logic [2:0]        reg_idx;

  logic              s1_valid_q;
  logic signed [16:0] s1_temp_q;
  logic signed [7:0] s1_cap_q;
  logic [31:0]       s1_now_q;
  logic              accept;
  logic              s1_adv;

  logic              out_valid_q;
  ctl_pkg::res_t     out_res_q;
  ctl_pkg::res_t     res;
  ctl_pkg::band_t    band;

  // Configuration registers.
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ctl_pkg::ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sel_mode        <= ctl_pkg::MODE_OEM;
      cfg_q.custom_limit    <= 4'(ctl_pkg::LIM_BALANCED);
      cfg_q.protect_eighty  <= 1'b0;
      cfg_q.smart_charging  <= 1'b0;
      cfg_q.night_guard     <= 1'b0;
      cfg_q.charger_present <= 1'b1;
    end else if (wr_en) begin
      unique case (reg_idx)
        ctl_pkg::REG_USER_MODE:       cfg_q.sel_mode <= ctl_pkg::mode_e'(pwdata[2:0]);
        ctl_pkg::REG_CUSTOM_LIMIT:    cfg_q.custom_limit <= pwdata[3:0];
        ctl_pkg::REG_PROTECT_EIGHTY:  cfg_q.protect_eighty <= pwdata[0];
        ctl_pkg::REG_SMART_CHARGING:  cfg_q.smart_charging <= pwdata[0];
        ctl_pkg::REG_NIGHT_CHARGING:  cfg_q.night_guard <= pwdata[0];
        ctl_pkg::REG_CHARGER_PRESENT: cfg_q.charger_present <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      ctl_pkg::REG_USER_MODE:       prdata = {29'd0, cfg_q.sel_mode};
      ctl_pkg::REG_CUSTOM_LIMIT:    prdata = {28'd0, cfg_q.custom_limit};
      ctl_pkg::REG_PROTECT_EIGHTY:  prdata = {31'd0, cfg_q.protect_eighty};
      ctl_pkg::REG_SMART_CHARGING:  prdata = {31'd0, cfg_q.smart_charging};
      ctl_pkg::REG_NIGHT_CHARGING:  prdata = {31'd0, cfg_q.night_guard};
      ctl_pkg::REG_CHARGER_PRESENT: prdata = {31'd0, cfg_q.charger_present};
      default:                      prdata = '0;
    endcase
  end

  // Stage handshakes: the input stage moves on whenever the result
  // register is empty or is being taken.
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_temp_q <= raw_temperature_i;
      s1_cap_q  <= capacity_reading_i;
      s1_now_q  <= now_seconds_i;
    end
  end

  ctl_band u_band (
    .raw_temperature_i (s1_temp_q),
    .band_o            (band)
  );

  ctl_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (s1_adv),
    .cfg_i      (cfg_q),
    .band_i     (band),
    .capacity_i (s1_cap_q),
    .now_i      (s1_now_q),
    .res_o      (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign applied_mode_o      = out_res_q.applied_mode;
  assign chg_limit_o         = out_res_q.chg_limit;
  assign chg_suspend_o       = out_res_q.chg_suspend;
  assign smart_out_o         = out_res_q.smart_out;
  assign night_out_o         = out_res_q.night_out;
  assign renegotiate_pulse_o = out_res_q.renegotiate_pulse;
  assign derate_hold_o       = out_res_q.derate_hold;
  assign hands_off_o         = out_res_q.hands_off;

  // A hands-off result applies nothing.
  a_hands_off_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hands_off_o |-> applied_mode_o == 3'(ctl_pkg::MODE_OEM) &&
      chg_limit_o == 5'd0 && !chg_suspend_o && !renegotiate_pulse_o)
    else $error("hands-off result drives charger settings");

  // Input suspend goes together with the cutoff limit.
  a_suspend_cutoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> chg_suspend_o == (chg_limit_o == ctl_pkg::LIM_CUTOFF))
    else $error("input suspend and cutoff limit disagree");

  // Renegotiation is only requested for fast, violent or custom modes.
  a_pulse_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && renegotiate_pulse_o |->
      applied_mode_o == 3'(ctl_pkg::MODE_FAST) ||
      applied_mode_o == 3'(ctl_pkg::MODE_VIOLENT) ||
      applied_mode_o == 3'(ctl_pkg::MODE_CUSTOM))
    else $error("renegotiation pulse in a mode that does not request it");

  // A held transaction in the input stage is never dropped.
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q)
    else $error("input stage lost a waiting transaction");

endmodule
